### sv/pebs_pkg.sv
// ----------------------------------------------------------------------------
// pebs_pkg - shared types and helpers for the priority expiration scheduler
// Transfer payloads, status codes, sequencer states and a lowest-set-bit
// encoder.
// ----------------------------------------------------------------------------
package pebs_pkg;

    localparam int LINKS       = 16;
    localparam int PRIORITIES  = 4;
    localparam int EXPIRATIONS = 1024;
    localparam int SEGMENTS    = 65536;

    localparam int LINK_W = $clog2(LINKS);
    localparam int PRIO_W = $clog2(PRIORITIES);
    localparam int EXP_W  = $clog2(EXPIRATIONS);
    localparam int SEG_W  = $clog2(SEGMENTS);

    // expiration bitmap: 32-bit words, one summary bit per word
    localparam int BIT_W  = 5;
    localparam int WORD_W = EXP_W - BIT_W;
    localparam int ROW_W  = LINK_W + PRIO_W;
    localparam int BM_AW  = ROW_W + WORD_W;
    localparam int BKT_W  = ROW_W + EXP_W;

    localparam logic [1:0] STATUS_STORED    = 2'd0;
    localparam logic [1:0] STATUS_RETRIEVED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_GET   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  link_index;
        logic [1:0]  priority_req;
        logic [9:0]  expiration;
        logic [15:0] segment_id;
        logic [15:0] link_mask;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_segment;
        logic [3:0]  out_link;
        logic [1:0]  out_priority;
        logic [9:0]  out_expiration;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ST_RD,
        S_ST_WR,
        S_G_LINK,
        S_G_SUM,
        S_G_EVAL,
        S_G_POP1,
        S_G_POP2,
        S_G_POP3,
        S_OUT
    } state_t;

    function automatic logic [BIT_W-1:0] lowbit(input logic [31:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### sv/priority_expiration_bundle_scheduler.sv
// ----------------------------------------------------------------------------
// priority_expiration_bundle_scheduler - strict priority, earliest expiry
// LIFO buckets of segment ids per link, priority and expiration.
// ----------------------------------------------------------------------------
// channel  ports               payload     role
// s_       s_valid / s_ready   in_item_t   store or get request
// m_       m_valid / m_ready   out_item_t  one result per request
//
// Store: accept, read, write, result. Get: accept, then per priority a scan
// of every link, with a summary row read for each enabled link with a live
// row and a bitmap word read where its summary allows; S_G_POP1 to S_G_POP3
// for a pop, then the result. Row valid flops cleared at reset mark summary rows,
// summary bits mark bitmap words, so no clearing pass.
// One request at a time; a stalled result holds the block.
// ----------------------------------------------------------------------------
module priority_expiration_bundle_scheduler (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pebs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pebs_pkg::out_item_t m_data
);
    import pebs_pkg::*;

    state_t state_reg, state_next;
    in_item_t in_reg, in_next;
    logic [LINK_W-1:0] l_reg, l_next, best_l_reg, best_l_next;
    logic [PRIO_W-1:0] p_reg, p_next;
    logic [EXP_W-1:0]  best_e_reg, best_e_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [SEG_W-1:0]  top_reg, top_next;
    logic found_reg, found_next;
    out_item_t m_data_reg, m_data_next;
    logic m_valid_reg, m_valid_next;
    logic [(1 << ROW_W)-1:0] row_vld_reg, row_vld_next;

    logic head_we, head_re, next_we, next_re, bm_we, bm_re, sum_we, sum_re;
    logic [BKT_W-1:0] head_waddr, head_raddr;
    logic [SEG_W-1:0] head_wdata, head_rdata, next_waddr, next_raddr;
    logic [SEG_W-1:0] next_wdata, next_rdata;
    logic [BM_AW-1:0] bm_waddr, bm_raddr;
    logic [31:0]      bm_wdata, bm_rdata;
    logic [ROW_W-1:0] sum_waddr, sum_raddr;
    logic [31:0]      sum_wdata, sum_rdata;

    logic [31:0]      cur_sum;
    logic [WORD_W-1:0] cur_w;
    logic [EXP_W-1:0] cand_e;
    logic             adv;
    logic [ROW_W-1:0] st_row, best_row;
    logic [31:0]      st_sum, st_word, pop_word;
    logic             st_live;

    pebs_ram #(.WIDTH(SEG_W), .DEPTH(1 << BKT_W)) u_head (
        .aclk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );
    pebs_ram #(.WIDTH(SEG_W), .DEPTH(SEGMENTS)) u_next (
        .aclk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .re(next_re), .raddr(next_raddr), .rdata(next_rdata)
    );
    pebs_ram #(.WIDTH(32), .DEPTH(1 << BM_AW)) u_bitmap (
        .aclk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
        .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
    );
    pebs_ram #(.WIDTH(32), .DEPTH(1 << ROW_W)) u_summary (
        .aclk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign cur_sum  = sum_rdata;
    assign cur_w    = WORD_W'(lowbit(cur_sum));
    assign cand_e   = {w_reg, lowbit(bm_rdata)};
    assign st_row   = {in_reg.link_index, in_reg.priority_req};
    assign best_row = {best_l_reg, p_reg};
    assign st_sum   = row_vld_reg[st_row] ? sum_rdata : 32'd0;
    assign st_live  = st_sum[in_reg.expiration[EXP_W-1:BIT_W]];
    assign st_word  = (st_live ? bm_rdata : 32'd0)
                      | (32'd1 << in_reg.expiration[BIT_W-1:0]);
    assign pop_word = bm_rdata & ~(32'd1 << best_e_reg[BIT_W-1:0]);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) begin
                state_next = (s_data.operation == OP_GET) ? S_G_LINK : S_ST_RD;
            end
            S_ST_RD:  state_next = S_ST_WR;
            S_ST_WR:  state_next = S_OUT;
            S_G_LINK, S_G_SUM, S_G_EVAL: begin
                if (!adv) begin
                    state_next = (state_reg == S_G_LINK) ? S_G_SUM : S_G_EVAL;
                end else if (l_reg == LINK_W'(LINKS - 1)) begin
                    if (found_next) begin
                        state_next = S_G_POP1;
                    end else if (p_reg == PRIO_W'(PRIORITIES - 1)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_G_LINK;
                    end
                end else begin
                    state_next = S_G_LINK;
                end
            end
            S_G_POP1: state_next = S_G_POP2;
            S_G_POP2: state_next = S_G_POP3;
            S_G_POP3: state_next = S_OUT;
            S_OUT:    if (m_ready) begin
                state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        in_next      = in_reg;
        l_next       = l_reg;
        p_next       = p_reg;
        best_l_next  = best_l_reg;
        best_e_next  = best_e_reg;
        w_next       = w_reg;
        top_next     = top_reg;
        found_next   = found_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        row_vld_next = row_vld_reg;
        adv          = 1'b0;
        sum_we = 1'b0; sum_waddr = st_row; sum_wdata = st_sum;
        sum_re = 1'b0; sum_raddr = st_row;
        head_we = 1'b0; head_waddr = {st_row, in_reg.expiration};
        head_wdata = in_reg.segment_id;
        head_re = 1'b0; head_raddr = {st_row, in_reg.expiration};
        next_we = 1'b0; next_waddr = in_reg.segment_id; next_wdata = in_reg.segment_id;
        next_re = 1'b0; next_raddr = head_rdata;
        bm_we = 1'b0; bm_waddr = {st_row, in_reg.expiration[EXP_W-1:BIT_W]};
        bm_wdata = st_word;
        bm_re = 1'b0; bm_raddr = {st_row, in_reg.expiration[EXP_W-1:BIT_W]};

        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                in_next    = s_data;
                l_next     = '0;
                p_next     = '0;
                found_next = 1'b0;
            end
            S_ST_RD: begin
                head_re = 1'b1;
                bm_re   = 1'b1;
                sum_re  = 1'b1;
            end
            S_ST_WR: begin
                next_we = 1'b1;
                if (st_live && bm_rdata[in_reg.expiration[BIT_W-1:0]]) begin
                    next_wdata = head_rdata;
                end
                head_we   = 1'b1;
                bm_we     = 1'b1;
                sum_we    = 1'b1;
                sum_wdata = st_sum | (32'd1 << in_reg.expiration[EXP_W-1:BIT_W]);
                row_vld_next[st_row] = 1'b1;
                m_data_next  = '0;
                m_data_next.status = STATUS_STORED;
                m_valid_next = 1'b1;
            end
            S_G_LINK, S_G_SUM, S_G_EVAL: begin
                if (state_reg == S_G_LINK) begin
                    if (in_reg.link_mask[l_reg] && row_vld_reg[{l_reg, p_reg}]) begin
                        sum_re    = 1'b1;
                        sum_raddr = {l_reg, p_reg};
                    end else begin
                        adv = 1'b1;
                    end
                end else if (state_reg == S_G_SUM) begin
                    if ((cur_sum != 32'd0)
                            && (!found_reg || cur_w <= best_e_reg[EXP_W-1:BIT_W])) begin
                        bm_re    = 1'b1;
                        bm_raddr = {l_reg, p_reg, cur_w};
                        w_next   = cur_w;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    adv = 1'b1;
                    if (!found_reg || cand_e < best_e_reg) begin
                        found_next  = 1'b1;
                        best_e_next = cand_e;
                        best_l_next = l_reg;
                    end
                end
                if (adv) begin
                    if (l_reg == LINK_W'(LINKS - 1)) begin
                        if (!found_next) begin
                            if (p_reg == PRIO_W'(PRIORITIES - 1)) begin
                                m_data_next  = '0;
                                m_data_next.status = STATUS_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                p_next = p_reg + 1'b1;
                                l_next = '0;
                            end
                        end
                    end else begin
                        l_next = l_reg + 1'b1;
                    end
                end
            end
            S_G_POP1: begin
                head_re    = 1'b1;
                head_raddr = {best_row, best_e_reg};
                bm_re      = 1'b1;
                bm_raddr   = {best_row, best_e_reg[EXP_W-1:BIT_W]};
                sum_re     = 1'b1;
                sum_raddr  = best_row;
            end
            S_G_POP2: begin
                top_next   = head_rdata;
                next_re    = 1'b1;
                next_raddr = head_rdata;
            end
            S_G_POP3: begin
                if (next_rdata == top_reg) begin
                    bm_we    = 1'b1;
                    bm_waddr = {best_row, best_e_reg[EXP_W-1:BIT_W]};
                    bm_wdata = pop_word;
                    if (pop_word == 32'd0) begin
                        sum_we    = 1'b1;
                        sum_waddr = best_row;
                        sum_wdata = sum_rdata
                                    & ~(32'd1 << best_e_reg[EXP_W-1:BIT_W]);
                    end
                end else begin
                    head_we    = 1'b1;
                    head_waddr = {best_row, best_e_reg};
                    head_wdata = next_rdata;
                end
                m_data_next.status         = STATUS_RETRIEVED;
                m_data_next.out_segment    = top_reg;
                m_data_next.out_link       = best_l_reg;
                m_data_next.out_priority   = p_reg;
                m_data_next.out_expiration = best_e_reg;
                m_valid_next = 1'b1;
            end
            S_OUT: if (m_ready) begin
                m_valid_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            row_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            row_vld_reg <= row_vld_next;
        end
        in_reg     <= in_next;
        l_reg      <= l_next;
        p_reg      <= p_next;
        best_l_reg <= best_l_next;
        best_e_reg <= best_e_next;
        w_reg      <= w_next;
        top_reg    <= top_next;
        m_data_reg <= m_data_next;
    end

    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted twice");
    a_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_RETRIEVED) |-> (m_data.out_segment == '0))
        else $error("stray segment in result");

endmodule

### sv/pebs_ram.sv
// ----------------------------------------------------------------------------
// pebs_ram - generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module pebs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the priority expiration scheduler
// Drives store and get requests over the s_ channel, predicts each result
// from a local model of the LIFO buckets, and compares every m_ transfer
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import pebs_pkg::*;

    localparam int NBKT      = LINKS * PRIORITIES * EXPIRATIONS;
    localparam int LIMIT     = 1500000;
    localparam int N_RANDOM  = 1250;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    priority_expiration_bundle_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // model state
    logic [15:0] top_id   [NBKT];
    bit          occupied [NBKT];
    logic [15:0] below_id [SEGMENTS];

    out_item_t   pending_q[$];
    int          mismatches;
    int          table_errs;
    int          cycles;
    bit          quiet_stretch;

    typedef struct {
        in_item_t  req;
        bit        fixed;
        out_item_t want;
    } row_t;

    row_t        rows[$];

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int bucket_no(int l, int p, int e);
        return (l * PRIORITIES + p) * EXPIRATIONS + e;
    endfunction

    function automatic out_item_t schedule(in_item_t r);
        out_item_t o;
        int b;
        bit hit;
        int best_e, best_l;
        o = '0;
        if (r.operation == OP_STORE) begin
            b = bucket_no(int'(r.link_index), int'(r.priority_req), int'(r.expiration));
            below_id[r.segment_id] = occupied[b] ? top_id[b] : r.segment_id;
            top_id[b] = r.segment_id;
            occupied[b] = 1'b1;
            o.status = STATUS_STORED;
            return o;
        end
        for (int p = 0; p < PRIORITIES; p++) begin
            hit = 0;
            best_e = 0;
            best_l = 0;
            for (int l = 0; l < LINKS; l++) begin
                if (r.link_mask[l]) begin
                    for (int e = 0; e < EXPIRATIONS; e++) begin
                        if (hit && e >= best_e) break;
                        if (occupied[bucket_no(l, p, e)]) begin
                            hit = 1;
                            best_e = e;
                            best_l = l;
                            break;
                        end
                    end
                end
            end
            if (hit) begin
                b = bucket_no(best_l, p, best_e);
                o.status = STATUS_RETRIEVED;
                o.out_segment = top_id[b];
                o.out_link = 4'(best_l);
                o.out_priority = 2'(p);
                o.out_expiration = 10'(best_e);
                if (below_id[top_id[b]] == top_id[b]) occupied[b] = 1'b0;
                else top_id[b] = below_id[top_id[b]];
                return o;
            end
        end
        o.status = STATUS_EMPTY;
        return o;
    endfunction

    function automatic in_item_t mk(bit op, int l, int p, int e, int s, int m);
        in_item_t r;
        r.operation = op;
        r.link_index = 4'(l);
        r.priority_req = 2'(p);
        r.expiration = 10'(e);
        r.segment_id = 16'(s);
        r.link_mask = 16'(m);
        return r;
    endfunction

    function automatic out_item_t res(int st, int s, int l, int p, int e);
        out_item_t o;
        o.status = 2'(st);
        o.out_segment = 16'(s);
        o.out_link = 4'(l);
        o.out_priority = 2'(p);
        o.out_expiration = 10'(e);
        return o;
    endfunction

    function automatic void add(in_item_t r, bit f, out_item_t w);
        row_t x;
        x.req = r;
        x.fixed = f;
        x.want = w;
        rows.insert(rows.size(), x);
    endfunction

    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < 22);
    endfunction

    task automatic send(in_item_t r);
        while (idle_now()) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (aresetn) m_ready <= !idle_now();
        else m_ready <= 1'b0;
        if (aresetn && s_valid && s_ready) begin
            pending_q.insert(pending_q.size(), schedule(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                if (mismatches + table_errs < 10) $display("unexpected result %p", m_data);
                mismatches = mismatches + 1;
            end else begin
                if (pending_q[0] !== m_data) begin
                    if (mismatches + table_errs < 10)
                        $display("mismatch: expected %p actual %p", pending_q[0], m_data);
                    mismatches = mismatches + 1;
                end
                void'(pending_q.pop_front());
            end
        end
    end

    initial begin
        in_item_t r;
        int kind;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        quiet_stretch = 0;
        for (int i = 0; i < NBKT; i++) occupied[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty after reset, extremes, tie on link, LIFO, mask
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 1, res(STATUS_EMPTY, 0, 0, 0, 0));
        add(mk(OP_STORE, 15, 3, 1023, 65535, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_GET, 0, 0, 0, 0, 16'h7FFF), 1, res(STATUS_EMPTY, 0, 0, 0, 0));
        add(mk(OP_GET, 0, 0, 0, 0, 16'h8000), 1,
            res(STATUS_RETRIEVED, 65535, 15, 3, 1023));
        add(mk(OP_STORE, 0, 0, 0, 0, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_GET, 0, 0, 0, 0, 16'h0001), 1, res(STATUS_RETRIEVED, 0, 0, 0, 0));
        add(mk(OP_STORE, 5, 1, 7, 100, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_STORE, 3, 1, 7, 101, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_STORE, 3, 1, 7, 102, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_STORE, 9, 2, 0, 103, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_STORE, 8, 1, 6, 104, 0), 1, res(STATUS_STORED, 0, 0, 0, 0));
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFF7), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 0, '0);
        add(mk(OP_STORE, 2, 0, 4, 200, 0), 0, '0);
        add(mk(OP_STORE, 2, 0, 4, 200, 0), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'h0004), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 0, '0);
        add(mk(OP_GET, 0, 0, 0, 0, 16'h0000), 1, res(STATUS_EMPTY, 0, 0, 0, 0));
        add(mk(OP_GET, 0, 0, 0, 0, 16'hFFFF), 1, res(STATUS_EMPTY, 0, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].fixed) begin
                // predictor must agree with the table before the block is compared
                r = rows[i].req;
                send(r);
                if (pending_q.size() > 0 && pending_q[$] !== rows[i].want) begin
                    if (mismatches + table_errs < 10)
                        $display("table row %0d: expected %p model %p", i,
                                 rows[i].want, pending_q[$]);
                    table_errs = table_errs + 1;
                end
            end else begin
                send(rows[i].req);
            end
        end

        // random: stores and gets mixed evenly, stores mostly on narrow fields so buckets collide
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_stretch = (n >= 500 && n < 650);
            kind = $urandom_range(99);
            if (kind < 50) begin
                r = mk(OP_STORE, $urandom_range(15), $urandom_range(3),
                       (kind < 40) ? $urandom_range(7) : $urandom_range(1023),
                       (kind < 30) ? $urandom_range(63) : $urandom(),
                       $urandom());
            end else begin
                r = mk(OP_GET, $urandom(), $urandom(), $urandom(), $urandom(),
                       (kind < 85) ? 16'hFFFF : $urandom());
            end
            send(r);
        end
        quiet_stretch = 0;

        while (pending_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && table_errs == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
